// ===== design/tbcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tbcf_pkg: shared definitions for the tape block crc framer
// Output kind codes, register indexes, crc constants and the work descriptor
// handed from the front end to the back end.
// ----------------------------------------------------------------------------
package tbcf_pkg;

  localparam int SEGMENT_BYTES_DEF = 256;
  localparam int MAX_TRAILER_DEF   = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam int BYTE_W  = 8;
  localparam int TRAIL_W = 6;
  localparam int CRC_W   = 16;
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 2;

  localparam logic [KIND_W-1:0] KIND_SYNC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CRC   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TRAIL = 2'd3;

  localparam logic [INDEX_W-1:0] REG_SYNC    = 2'd0;
  localparam logic [INDEX_W-1:0] REG_TRAILER = 2'd1;

  localparam logic [BYTE_W-1:0]  SYNC_RESET    = 8'd22;
  localparam logic [TRAIL_W-1:0] TRAILER_RESET = 6'd4;
  localparam logic [BYTE_W-1:0]  TRAILER_FILL  = 8'hFF;

  localparam logic [CRC_W-1:0] CRC_PRESET   = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_STEP_XOR = 16'h0810;

  // one accepted byte, fully classified
  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [BYTE_W-1:0]  sync;
    logic [CRC_W-1:0]   crc;
    logic [TRAIL_W-1:0] trail;
    logic               need_sync;
    logic               send_crc;
    logic               last;
    logic               is_short;
  } desc_t;

  // one byte of crc-16 (poly 0x1021), msb first
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0]  c;
    logic [BYTE_W-1:0] d;
    c = crc_in;
    d = data;
    for (int i = 0; i < BYTE_W; i++) begin
      if (d[BYTE_W-1] ^ c[CRC_W-1]) begin
        c = ((c ^ CRC_STEP_XOR) << 1) | CRC_W'(1);
      end else begin
        c = c << 1;
      end
      d = d << 1;
    end
    return c;
  endfunction

endpackage

// ===== design/tbcf_front.sv =====
// ----------------------------------------------------------------------------
// tbcf_front: input side of the tape block crc framer
// Holds the configuration registers and the running segment state, accepts
// payload bytes and turns each into a work descriptor for the queue.
// ----------------------------------------------------------------------------
module tbcf_front #(
  parameter int SEGMENT_BYTES = tbcf_pkg::SEGMENT_BYTES_DEF,
  parameter int MAX_TRAILER   = tbcf_pkg::MAX_TRAILER_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tbcf_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [tbcf_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [tbcf_pkg::BYTE_W-1:0]    data_byte,
  input  logic                           last_byte,
  input  logic                           q_full,
  output logic                           push,
  output tbcf_pkg::desc_t                push_desc
);

  localparam int SEG_W = (SEGMENT_BYTES > 2) ? $clog2(SEGMENT_BYTES) : 1;
  localparam logic [SEG_W-1:0] SEG_END = SEG_W'(SEGMENT_BYTES - 1);
  localparam logic [tbcf_pkg::TRAIL_W-1:0] TRAIL_MAX = tbcf_pkg::TRAIL_W'(MAX_TRAILER);

  logic [tbcf_pkg::BYTE_W-1:0]  sync_byte;
  logic [tbcf_pkg::TRAIL_W-1:0] trailer_length;
  logic [tbcf_pkg::CRC_W-1:0]   crc_register;
  logic [SEG_W-1:0]             segment_count;
  logic                         block_open;

  logic [tbcf_pkg::CRC_W-1:0]   crc_next;
  logic                         seg_full;

  assign cfg_ready  = 1'b1;
  assign item_ready = !q_full;
  assign push       = item_valid && item_ready;

  assign crc_next = tbcf_pkg::crc16_byte(crc_register, data_byte);
  assign seg_full = (segment_count == SEG_END);

  always_comb begin
    push_desc           = '0;
    push_desc.data      = data_byte;
    push_desc.sync      = sync_byte;
    push_desc.crc       = ~crc_next;
    push_desc.trail     = (trailer_length > TRAIL_MAX) ? TRAIL_MAX : trailer_length;
    push_desc.need_sync = !block_open;
    push_desc.send_crc  = seg_full || last_byte;
    push_desc.last      = last_byte;
    push_desc.is_short  = last_byte && !seg_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte      <= tbcf_pkg::SYNC_RESET;
      trailer_length <= tbcf_pkg::TRAILER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tbcf_pkg::REG_SYNC:    sync_byte      <= cfg_data;
        tbcf_pkg::REG_TRAILER: trailer_length <= cfg_data[tbcf_pkg::TRAIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register  <= tbcf_pkg::CRC_PRESET;
      segment_count <= '0;
      block_open    <= 1'b0;
    end else if (push) begin
      if (seg_full || last_byte) begin
        crc_register  <= tbcf_pkg::CRC_PRESET;
        segment_count <= '0;
      end else begin
        crc_register  <= crc_next;
        segment_count <= segment_count + SEG_W'(1);
      end
      block_open <= !last_byte;
    end
  end

endmodule

// ===== design/tbcf_queue.sv =====
// ----------------------------------------------------------------------------
// tbcf_queue: descriptor queue
// Short first-in first-out store between the front end and the back end.
// ----------------------------------------------------------------------------
module tbcf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tbcf_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output tbcf_pkg::desc_t head
);

  localparam int DEPTH = tbcf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  tbcf_pkg::desc_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/tbcf_back.sv =====
// ----------------------------------------------------------------------------
// tbcf_back: output sequencer
// Walks each descriptor through the sync, data, crc and trailer bytes it needs
// and drives the registered output stage, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module tbcf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  tbcf_pkg::desc_t               head,
  output logic                          pop,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [tbcf_pkg::BYTE_W-1:0]   out_byte,
  output logic [tbcf_pkg::KIND_W-1:0]   out_kind,
  output logic                          out_last,
  output logic                          short_segment
);

  localparam logic [2:0] PH_SYNC   = 3'd0;
  localparam logic [2:0] PH_DATA   = 3'd1;
  localparam logic [2:0] PH_CRC_HI = 3'd2;
  localparam logic [2:0] PH_CRC_LO = 3'd3;
  localparam logic [2:0] PH_TRAIL  = 3'd4;

  logic [2:0]                   phase;
  logic [2:0]                   phase_next;
  logic [2:0]                   cur_phase;
  logic [tbcf_pkg::TRAIL_W-1:0] trail_count;
  logic                         advance;
  logic                         emit;
  logic                         finish;
  logic                         has_trail;
  logic [tbcf_pkg::BYTE_W-1:0]  byte_sel;
  logic [tbcf_pkg::KIND_W-1:0]  kind_sel;

  assign advance   = !result_valid || result_ready;
  assign emit      = head_valid && advance;
  assign pop       = emit && finish;
  assign has_trail = head.last && (head.trail != '0);
  assign cur_phase = (phase == PH_SYNC && !head.need_sync) ? PH_DATA : phase;

  always_comb begin
    byte_sel   = head.data;
    kind_sel   = tbcf_pkg::KIND_DATA;
    finish     = 1'b0;
    phase_next = phase;
    unique case (cur_phase)
      PH_SYNC: begin
        byte_sel   = head.sync;
        kind_sel   = tbcf_pkg::KIND_SYNC;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        finish     = !head.send_crc && !has_trail;
        phase_next = head.send_crc ? PH_CRC_HI : PH_TRAIL;
      end
      PH_CRC_HI: begin
        byte_sel   = head.crc[15:8];
        kind_sel   = tbcf_pkg::KIND_CRC;
        phase_next = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        byte_sel   = head.crc[7:0];
        kind_sel   = tbcf_pkg::KIND_CRC;
        finish     = !has_trail;
        phase_next = PH_TRAIL;
      end
      PH_TRAIL: begin
        byte_sel   = tbcf_pkg::TRAILER_FILL;
        kind_sel   = tbcf_pkg::KIND_TRAIL;
        finish     = (trail_count == head.trail - tbcf_pkg::TRAIL_W'(1));
        phase_next = PH_TRAIL;
      end
      default: begin
        finish     = 1'b1;
        phase_next = PH_SYNC;
      end
    endcase
    if (finish) begin
      phase_next = PH_SYNC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC;
      trail_count <= '0;
    end else if (emit) begin
      phase <= phase_next;
      if (finish) begin
        trail_count <= '0;
      end else if (cur_phase == PH_TRAIL) begin
        trail_count <= trail_count + tbcf_pkg::TRAIL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte      <= byte_sel;
      out_kind      <= kind_sel;
      out_last      <= finish && head.last;
      short_segment <= head.is_short;
    end
  end

endmodule

// ===== design/tape_block_crc_framer.sv =====
// ----------------------------------------------------------------------------
// tape_block_crc_framer: crc-16 framing of a cassette tape data block
// Sync byte ahead of the block, crc after every full segment and after a
// short final segment, 0xff trailer after the last byte.
// ----------------------------------------------------------------------------
// an item's results pass the descriptor queue, then the registered output stage
// throughput: one output byte per cycle while a descriptor waits and the output is not
//   stalled; besides data bytes the back-end sequencer emits sync, 2 crc and trailer bytes
// the 2-entry descriptor queue takes input while the output stalls, until it is full
// reset: synchronous, clears queue, sequencer and segment state, sync 22 and trailer 4
// no clearing pass after reset; the block accepts transactions in the next cycle
module tape_block_crc_framer #(
  parameter int SEGMENT_BYTES = tbcf_pkg::SEGMENT_BYTES_DEF,
  parameter int MAX_TRAILER   = tbcf_pkg::MAX_TRAILER_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tbcf_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [tbcf_pkg::BYTE_W-1:0]   cfg_data,
  // payload byte stream
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [tbcf_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          last_byte,
  // framed tape stream
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [tbcf_pkg::BYTE_W-1:0]   out_byte,
  output logic [tbcf_pkg::KIND_W-1:0]   out_kind,
  output logic                          out_last,
  output logic                          short_segment
);

  // descriptor path between the two halves
  tbcf_pkg::desc_t push_desc;
  tbcf_pkg::desc_t head;
  logic            push;
  logic            q_full;
  logic            pop;
  logic            head_valid;

  // front end: config registers, running crc, segment counter, block state
  tbcf_front #(
    .SEGMENT_BYTES (SEGMENT_BYTES),
    .MAX_TRAILER   (MAX_TRAILER)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .q_full     (q_full),
    .push       (push),
    .push_desc  (push_desc)
  );

  // short queue so that input and output can stall independently
  tbcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back end: expands each descriptor into sync, data, crc and trailer bytes
  tbcf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_last      (out_last),
    .short_segment (short_segment)
  );

  // the block always closes on a crc or trailer byte
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_last |->
      out_kind == tbcf_pkg::KIND_CRC || out_kind == tbcf_pkg::KIND_TRAIL)
    else $error("framed block closed on a sync or data byte");

  // every accepted input transaction is followed by a valid byte in the output register
  a_item_reaches_output: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |-> ##2 result_valid)
    else $error("accepted transaction produced no result");

  // a descriptor only leaves the queue when the output stage takes a byte
  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid && (!result_valid || result_ready))
    else $error("queue popped without room in the output stage");

  // a waiting output transaction holds its byte and flags until taken
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(out_byte) && $stable(out_kind) &&
      $stable(out_last) && $stable(short_segment))
    else $error("output transaction changed while stalled");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the tape block crc framer
// Drives payload bytes and register writes over valid/ready, predicts the
// framed tape stream (sync, data, crc-16 and 0xff trailer bytes) with its own
// framing model, and checks every output transaction field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

  // run control
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 330;
  localparam int MAX_REPORTS  = 40;

  // crc-16 generator polynomial, msb first
  localparam logic [tbcf_pkg::CRC_W-1:0] CRC_POLY = 16'h1021;

  // register indexes beyond the two real registers, writes there are dropped
  localparam logic [tbcf_pkg::INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [tbcf_pkg::INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  // one byte of the framed tape stream
  typedef struct packed {
    logic [tbcf_pkg::BYTE_W-1:0] value;
    logic [tbcf_pkg::KIND_W-1:0] kind;
    logic                        last;
    logic                        short_seg;
  } tape_byte_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [tbcf_pkg::INDEX_W-1:0]  cfg_index;
  logic [tbcf_pkg::BYTE_W-1:0]   cfg_data;
  logic                          item_valid;
  logic                          item_ready;
  logic [tbcf_pkg::BYTE_W-1:0]   data_byte;
  logic                          last_byte;
  logic                          result_valid;
  logic                          result_ready;
  logic [tbcf_pkg::BYTE_W-1:0]   out_byte;
  logic [tbcf_pkg::KIND_W-1:0]   out_kind;
  logic                          out_last;
  logic                          short_segment;

  // framing model state: registers and per-block progress
  logic [tbcf_pkg::BYTE_W-1:0]   sync_reg;
  logic [tbcf_pkg::TRAIL_W-1:0]  trailer_reg;
  logic [tbcf_pkg::CRC_W-1:0]    crc_acc;
  int                            seg_fill;
  logic                          block_open;

  // bytes of the tape stream still owed by the block, oldest first
  tape_byte_t          pending_tape[$];
  // bytes produced by the payload byte being framed
  tape_byte_t          step_bytes[$];

  int                  errors;
  int                  cycles;
  int                  tape_seen;
  bit                  offering;
  bit                  src_gaps;
  bit                  sink_gaps;
  int                  hold_request;

  tape_block_crc_framer u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_last      (out_last),
    .short_segment (short_segment)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycles, pending_tape.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (errors < MAX_REPORTS) begin
      $display("mismatch at cycle %0d, tape byte %0d: %s", cycles, tape_seen, what);
    end
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // framing model
  // ---------------------------------------------------------------------------

  // shift one byte into the crc, msb first
  function automatic logic [tbcf_pkg::CRC_W-1:0] crc_shift_byte(
      input logic [tbcf_pkg::CRC_W-1:0] c, input logic [tbcf_pkg::BYTE_W-1:0] d);
    logic fb;
    for (int i = tbcf_pkg::BYTE_W - 1; i >= 0; i--) begin
      fb = c[tbcf_pkg::CRC_W-1] ^ d[i];
      c  = {c[tbcf_pkg::CRC_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void append_tape(input logic [tbcf_pkg::BYTE_W-1:0] v,
                                      input logic [tbcf_pkg::KIND_W-1:0] k);
    step_bytes.push_back('{value: v, kind: k, last: 1'b0, short_seg: 1'b0});
  endfunction

  // inverted crc, high byte first, then a fresh segment
  function automatic void append_crc();
    logic [tbcf_pkg::CRC_W-1:0] sent;
    sent = ~crc_acc;
    append_tape(sent[tbcf_pkg::CRC_W-1:tbcf_pkg::BYTE_W], tbcf_pkg::KIND_CRC);
    append_tape(sent[tbcf_pkg::BYTE_W-1:0], tbcf_pkg::KIND_CRC);
    crc_acc  = tbcf_pkg::CRC_PRESET;
    seg_fill = 0;
  endfunction

  // works out the tape bytes that one accepted payload byte causes
  function automatic void frame_payload_byte(input logic [tbcf_pkg::BYTE_W-1:0] d,
                                             input logic closing);
    int         trail;
    bit         cut_short;
    tape_byte_t entry;
    step_bytes.delete();
    cut_short = 1'b0;
    // the first byte of a block is preceded by the sync byte
    if (!block_open) begin
      append_tape(sync_reg, tbcf_pkg::KIND_SYNC);
      block_open = 1'b1;
    end
    append_tape(d, tbcf_pkg::KIND_DATA);
    crc_acc  = crc_shift_byte(crc_acc, d);
    seg_fill = seg_fill + 1;
    // a full segment always gets its crc, even when the block closes here
    if (seg_fill == tbcf_pkg::SEGMENT_BYTES_DEF) begin
      append_crc();
    end
    if (closing) begin
      // block closed part way through a segment: crc over what arrived, flagged
      if (seg_fill != 0) begin
        cut_short = 1'b1;
        append_crc();
      end
      trail = (trailer_reg > tbcf_pkg::MAX_TRAILER_DEF) ? tbcf_pkg::MAX_TRAILER_DEF
                                                        : int'(trailer_reg);
      repeat (trail) append_tape(tbcf_pkg::TRAILER_FILL, tbcf_pkg::KIND_TRAIL);
      crc_acc    = tbcf_pkg::CRC_PRESET;
      seg_fill   = 0;
      block_open = 1'b0;
    end
    foreach (step_bytes[i]) begin
      entry           = step_bytes[i];
      entry.short_seg = cut_short;
      // with no trailer the crc low byte ends the block
      entry.last      = closing && (i == step_bytes.size() - 1);
      pending_tape.push_back(entry);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // register write; keep leaves valid up for a write that follows at once
  task automatic write_reg(input logic [tbcf_pkg::INDEX_W-1:0] idx,
                           input logic [tbcf_pkg::BYTE_W-1:0] val, input bit keep);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == tbcf_pkg::REG_SYNC) begin
      sync_reg = val;
    end else if (idx == tbcf_pkg::REG_TRAILER) begin
      trailer_reg = val[tbcf_pkg::TRAIL_W-1:0];
    end
    if (!keep) begin
      cfg_valid <= 1'b0;
    end
  endtask

  // one payload transaction, with an occasional idle burst ahead of it
  task automatic send_byte(input logic [tbcf_pkg::BYTE_W-1:0] d, input logic closing);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_valid <= 1'b1;
    data_byte  <= d;
    last_byte  <= closing;
    offering = 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    frame_payload_byte(d, closing);
  endtask

  task automatic send_block(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(tbcf_pkg::BYTE_W'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // stop offering and wait until the block has handed over every owed byte
  task automatic wait_drained();
    if (offering) begin
      item_valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_tape.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side: pacing and checking
  // ---------------------------------------------------------------------------

  // receiver: random stall bursts, plus a long hold-off when a test asks
  initial begin : sink_pacing
    int stall_left;
    stall_left = 0;
    result_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) begin
          result_ready <= 1'b1;
        end
      end else if (hold_request > 0) begin
        result_ready <= 1'b0;
        stall_left   = hold_request;
        hold_request = 0;
      end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        stall_left   = $urandom_range(1, 10);
      end
    end
  end

  // every accepted output transaction against the oldest owed byte
  always @(posedge clk) begin : tape_check
    tape_byte_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_tape.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h kind %0d", out_byte, out_kind));
      end else begin
        want = pending_tape.pop_front();
        if (out_byte !== want.value) begin
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.value));
        end
        if (out_kind !== want.kind) begin
          report_mismatch($sformatf("out_kind %0d, want %0d", out_kind, want.kind));
        end
        if (out_last !== want.last) begin
          report_mismatch($sformatf("out_last %0b, want %0b", out_last, want.last));
        end
        if (short_segment !== want.short_seg) begin
          report_mismatch($sformatf("short_segment %0b, want %0b", short_segment,
                                    want.short_seg));
        end
      end
      tape_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // defaults straight out of reset: sync 22, four trailer bytes
  task automatic test_reset_values();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();
  endtask

  // register extremes: zero trailer, maximum trailer, saturation above it
  task automatic test_register_extremes();
    write_reg(tbcf_pkg::REG_SYNC, 8'hFF, 1'b1);
    write_reg(tbcf_pkg::REG_TRAILER, 8'h00, 1'b0);
    // no trailer, so the crc low byte carries out_last
    send_byte(8'hA5, 1'b1);
    wait_drained();
    write_reg(tbcf_pkg::REG_SYNC, 8'h00, 1'b1);
    write_reg(tbcf_pkg::REG_TRAILER, 8'(tbcf_pkg::MAX_TRAILER_DEF), 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_drained();
    // all ones: upper data bits dropped, 63 clipped to the maximum
    write_reg(tbcf_pkg::REG_TRAILER, 8'hFF, 1'b0);
    send_byte(8'h7E, 1'b1);
    wait_drained();
    // just over the maximum
    write_reg(tbcf_pkg::REG_TRAILER, 8'(tbcf_pkg::MAX_TRAILER_DEF + 1), 1'b0);
    send_byte(8'hC3, 1'b1);
    wait_drained();
  endtask

  // writes to indexes with no register behind them change nothing
  task automatic test_unused_index();
    write_reg(REG_SPARE_LO, 8'h00, 1'b1);
    write_reg(REG_SPARE_HI, 8'hFF, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    wait_drained();
  endtask

  // back-to-back blocks, each must reopen with its own sync byte
  task automatic test_block_chaining();
    write_reg(tbcf_pkg::REG_SYNC, 8'h3C, 1'b1);
    write_reg(tbcf_pkg::REG_TRAILER, 8'h01, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    wait_drained();
  endtask

  // random blocks under random settings; the first one covers the segment end
  task automatic test_random_blocks();
    int                           payload_sent;
    int                           blocks;
    int                           len;
    logic [tbcf_pkg::TRAIL_W-1:0] trail;
    payload_sent = 0;
    blocks       = 0;
    while (payload_sent < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 3))
        0:       trail = '0;
        1:       trail = tbcf_pkg::TRAIL_W'(tbcf_pkg::MAX_TRAILER_DEF);
        2:       trail = '1;
        default: trail = tbcf_pkg::TRAIL_W'($urandom_range(0, 63));
      endcase
      write_reg(tbcf_pkg::REG_SYNC, tbcf_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
      write_reg(tbcf_pkg::REG_TRAILER, {2'($urandom_range(0, 3)), trail}, 1'b0);
      repeat ($urandom_range(1, 3)) begin
        if (blocks == 0) begin
          // last byte lands exactly on the segment end: one crc only
          len = tbcf_pkg::SEGMENT_BYTES_DEF;
        end else if ($urandom_range(0, 7) == 0) begin
          len = 1;
        end else begin
          len = $urandom_range(2, 24);
        end
        send_block(len);
        payload_sent += len;
        blocks++;
      end
    end
    wait_drained();
  endtask

  // long receiver hold-off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    src_gaps     = 1'b0;
    sink_gaps    = 1'b0;
    hold_request = 400;
    for (int b = 0; b < 6; b++) begin
      send_block(8);
    end
    wait_drained();
  endtask

  // closing stretch at full rate on both sides
  task automatic test_streaming();
    write_reg(tbcf_pkg::REG_SYNC, 8'hA5, 1'b1);
    write_reg(tbcf_pkg::REG_TRAILER, 8'h02, 1'b0);
    for (int b = 0; b < 8; b++) begin
      send_block($urandom_range(1, 6));
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    errors       = 0;
    cycles       = 0;
    tape_seen    = 0;
    offering     = 1'b0;
    hold_request = 0;
    src_gaps     = 1'b1;
    sink_gaps    = 1'b1;
    // model starts from the block's reset state
    sync_reg     = tbcf_pkg::SYNC_RESET;
    trailer_reg  = tbcf_pkg::TRAILER_RESET;
    crc_acc      = tbcf_pkg::CRC_PRESET;
    seg_fill     = 0;
    block_open   = 1'b0;

    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_index  <= tbcf_pkg::REG_SYNC;
    cfg_data   <= '0;
    item_valid <= 1'b0;
    data_byte  <= '0;
    last_byte  <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_register_extremes();
    test_unused_index();
    test_block_chaining();
    test_random_blocks();
    test_output_backpressure();
    test_streaming();

    // let any stray transaction show up before the verdict
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_tape.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tbcf_pkg.sv
design/tbcf_front.sv
design/tbcf_queue.sv
design/tbcf_back.sv
design/tape_block_crc_framer.sv
tb/tb_top.sv
